[design/i2crs_pkg.sv]
// Shared types, codes and defaults for the I2C register access sequencer.
`timescale 1ns / 1ps

package i2crs_pkg;

    localparam int MAX_WRITE_BYTES_DEF = 32;

    // Item kinds
    localparam logic [1:0] ACT_START_RD = 2'd0;
    localparam logic [1:0] ACT_START_WR = 2'd1;
    localparam logic [1:0] ACT_LOAD     = 2'd2;
    localparam logic [1:0] ACT_EVENT    = 2'd3;

    // Engine commands
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_ADDR     = 3'd1;
    localparam logic [2:0] CMD_DATA     = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_ACK      = 3'd4;
    localparam logic [2:0] CMD_NACKSTOP = 3'd5;

    // Transaction status
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_REGNACK  = 3'd2;
    localparam logic [2:0] ST_ADDRNACK = 3'd3;
    localparam logic [2:0] ST_ARBLOST  = 3'd4;
    localparam logic [2:0] ST_REJECT   = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_REG  = 2'd2,
        PH_READ = 2'd3
    } t_phase;

    // Result of one item; command_byte comes from the buffer when use_buf is set
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] command_byte;
        logic       use_buf;
        logic [2:0] status;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [7:0] read_index;
    } t_result;

endpackage

[design/i2crs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module i2crs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = i2crs_pkg::MAX_WRITE_BYTES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/i2crs_ctrl.sv]
// Transaction sequencer: phase machine, counters and buffer access per item.
`timescale 1ns / 1ps

module i2crs_ctrl #(
    parameter int MAX_WRITE_BYTES = i2crs_pkg::MAX_WRITE_BYTES_DEF,
    localparam int AW = (MAX_WRITE_BYTES > 1) ? $clog2(MAX_WRITE_BYTES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [6:0]          i_target_address,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_reg_addr,
    input  logic [7:0]          i_byte_count,
    input  logic [4:0]          i_buffer_index,
    input  logic [7:0]          i_data_byte,
    input  logic                i_write_done_flag,
    input  logic                i_read_done_flag,
    input  logic                i_rx_nack,
    input  logic                i_clock_hold,
    output i2crs_pkg::t_result  o_res,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [7:0]          o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr
);

    localparam logic [8:0] MAXW = 9'(MAX_WRITE_BYTES);

    i2crs_pkg::t_phase r_phase, n_phase;
    logic       r_is_write, n_is_write;
    logic [7:0] r_register_address, n_register_address;
    logic [7:0] r_total_bytes, n_total_bytes;
    logic [7:0] r_bytes_done, n_bytes_done;
    logic [2:0] r_last_status, n_last_status;

    logic [7:0] addr_w;
    logic       count_ok;
    logic [8:0] slot_ext;
    logic [8:0] done_ext;
    logic       slot_ok;
    logic       done_in_buf;
    logic [7:0] done_inc;
    logic       send_data;

    assign addr_w      = {i_target_address, 1'b0};
    assign slot_ext    = 9'(i_buffer_index);
    assign done_ext    = 9'(r_bytes_done);
    assign slot_ok     = slot_ext < MAXW;
    assign done_in_buf = done_ext < MAXW;
    assign done_inc    = r_bytes_done + 8'd1;
    assign count_ok    = (i_action == i2crs_pkg::ACT_START_WR)
                       ? ((i_byte_count != 8'd0) && (9'(i_byte_count) <= MAXW))
                       : (i_byte_count != 8'd0);

    // Write-phase data byte send (buffer read) condition
    assign send_data = (i_action == i2crs_pkg::ACT_EVENT) && (r_phase == i2crs_pkg::PH_REG)
                     && i_write_done_flag && !i_rx_nack && r_is_write
                     && (r_bytes_done < r_total_bytes);

    assign o_wr_en   = i_accept && (i_action == i2crs_pkg::ACT_LOAD) && slot_ok;
    assign o_wr_addr = slot_ext[AW-1:0];
    assign o_wr_data = i_data_byte;
    assign o_rd_en   = i_accept && send_data && done_in_buf;
    assign o_rd_addr = done_ext[AW-1:0];

    // Next state
    always_comb begin
        n_phase            = r_phase;
        n_is_write         = r_is_write;
        n_register_address = r_register_address;
        n_total_bytes      = r_total_bytes;
        n_bytes_done       = r_bytes_done;
        n_last_status      = r_last_status;
        unique case (i_action) inside
            i2crs_pkg::ACT_START_RD, i2crs_pkg::ACT_START_WR: begin
                if (!count_ok) begin
                    n_phase       = i2crs_pkg::PH_IDLE;
                    n_last_status = i2crs_pkg::ST_REJECT;
                end else begin
                    n_is_write         = (i_action == i2crs_pkg::ACT_START_WR);
                    n_register_address = i_reg_addr;
                    n_total_bytes      = i_byte_count;
                    n_bytes_done       = 8'd0;
                    n_last_status      = i2crs_pkg::ST_BUSY;
                    n_phase            = i2crs_pkg::PH_ADDR;
                end
            end
            i2crs_pkg::ACT_LOAD: begin
            end
            default: begin
                unique case (r_phase)
                    i2crs_pkg::PH_ADDR: begin
                        if (i_write_done_flag) begin
                            if (i_clock_hold && !i_rx_nack) begin
                                n_phase = i2crs_pkg::PH_REG;
                            end else if (i_rx_nack) begin
                                n_last_status = i2crs_pkg::ST_ADDRNACK;
                                n_phase       = i2crs_pkg::PH_IDLE;
                            end else begin
                                n_last_status = i2crs_pkg::ST_ARBLOST;
                                n_phase       = i2crs_pkg::PH_IDLE;
                            end
                        end
                    end
                    i2crs_pkg::PH_REG: begin
                        if (i_write_done_flag) begin
                            if (i_rx_nack) begin
                                n_last_status = i2crs_pkg::ST_REGNACK;
                                n_phase       = i2crs_pkg::PH_IDLE;
                            end else if (!r_is_write) begin
                                n_phase = i2crs_pkg::PH_READ;
                            end else if (r_bytes_done >= r_total_bytes) begin
                                n_last_status = i2crs_pkg::ST_DONE;
                                n_phase       = i2crs_pkg::PH_IDLE;
                            end else begin
                                n_bytes_done = done_inc;
                            end
                        end
                    end
                    i2crs_pkg::PH_READ: begin
                        if (i_read_done_flag && i_clock_hold) begin
                            n_bytes_done = done_inc;
                            if (done_inc == r_total_bytes) begin
                                n_last_status = i2crs_pkg::ST_DONE;
                                n_phase       = i2crs_pkg::PH_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_res            = '0;
        o_res.status     = n_last_status;
        unique case (i_action) inside
            i2crs_pkg::ACT_START_RD, i2crs_pkg::ACT_START_WR: begin
                if (count_ok) begin
                    o_res.command      = i2crs_pkg::CMD_ADDR;
                    o_res.command_byte = addr_w;
                end
            end
            i2crs_pkg::ACT_LOAD: begin
            end
            default: begin
                unique case (r_phase)
                    i2crs_pkg::PH_ADDR: begin
                        if (i_write_done_flag) begin
                            if (i_clock_hold && !i_rx_nack) begin
                                o_res.command      = i2crs_pkg::CMD_DATA;
                                o_res.command_byte = r_register_address;
                            end else if (i_rx_nack) begin
                                o_res.command = i2crs_pkg::CMD_STOP;
                            end
                        end
                    end
                    i2crs_pkg::PH_REG: begin
                        if (i_write_done_flag) begin
                            if (i_rx_nack) begin
                                o_res.command = i2crs_pkg::CMD_STOP;
                            end else if (!r_is_write) begin
                                o_res.command      = i2crs_pkg::CMD_ADDR;
                                o_res.command_byte = addr_w | 8'h01;
                            end else if (r_bytes_done >= r_total_bytes) begin
                                o_res.command = i2crs_pkg::CMD_STOP;
                            end else begin
                                o_res.command = i2crs_pkg::CMD_DATA;
                                o_res.use_buf = done_in_buf;
                            end
                        end
                    end
                    i2crs_pkg::PH_READ: begin
                        if (i_read_done_flag && i_clock_hold) begin
                            o_res.read_valid = 1'b1;
                            o_res.read_byte  = i_data_byte;
                            o_res.read_index = r_bytes_done;
                            o_res.command    = (done_inc == r_total_bytes)
                                             ? i2crs_pkg::CMD_NACKSTOP : i2crs_pkg::CMD_ACK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= i2crs_pkg::PH_IDLE;
            r_is_write         <= 1'b0;
            r_register_address <= 8'd0;
            r_total_bytes      <= 8'd0;
            r_bytes_done       <= 8'd0;
            r_last_status      <= i2crs_pkg::ST_BUSY;
        end else if (i_accept) begin
            r_phase            <= n_phase;
            r_is_write         <= n_is_write;
            r_register_address <= n_register_address;
            r_total_bytes      <= n_total_bytes;
            r_bytes_done       <= n_bytes_done;
            r_last_status      <= n_last_status;
        end
    end

endmodule

[design/i2c_register_access_sequencer_core.sv]
// Top level of the I2C register access sequencer: config, result pipeline, buffer RAM.
//
// Usage: write the seven-bit target address through i_cfg_we / i_cfg_wdata while idle.
// Input items (start read, start write, load write byte, bus event) arrive on the
// i_valid / o_ready channel; each accepted item yields exactly one result on the
// o_valid / i_ready channel: an engine command with its byte, the transaction
// status, and a received byte with its index during reads.
// Each result is registered in stage 1 and then in the output register; the
// command is decided and the write-buffer read issued when the item is accepted,
// and the registered RAM data is taken into the output register from stage 1.
// Throughput: one item per cycle while not stalled, limited by one state update per item.
// Loads write the buffer RAM in the cycle they are accepted, so a following send
// always sees the new byte.
// Reset (synchronous, active low) returns the sequencer to idle with status busy
// and empties the pipeline; the buffer contents are undefined until loaded.
// When the receiver stalls, the output register and one staged result hold, and
// o_ready drops only once both are full.
`timescale 1ns / 1ps

module i2c_register_access_sequencer_core #(
    parameter int MAX_WRITE_BYTES = i2crs_pkg::MAX_WRITE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_byte_count,
    input  logic [4:0] i_buffer_index,
    input  logic [7:0] i_data_byte,
    input  logic       i_write_done_flag,
    input  logic       i_read_done_flag,
    input  logic       i_rx_nack,
    input  logic       i_clock_hold,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_command,
    output logic [7:0] o_command_byte,
    output logic [2:0] o_status,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte,
    output logic [7:0] o_read_index
);

    localparam int AW = (MAX_WRITE_BYTES > 1) ? $clog2(MAX_WRITE_BYTES) : 1;

    logic [6:0] r_target_address;

    logic               accept;
    i2crs_pkg::t_result res;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;

    logic               r_s1_valid;
    i2crs_pkg::t_result r_s1;
    logic               r_out_valid;
    i2crs_pkg::t_result r_out;
    logic               s1_move;
    i2crs_pkg::t_result n_out;

    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_address <= 7'd0;
        end else if (i_cfg_we) begin
            r_target_address <= i_cfg_wdata;
        end
    end

    i2crs_ctrl #(
        .MAX_WRITE_BYTES(MAX_WRITE_BYTES)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_target_address  (r_target_address),
        .i_action          (i_action),
        .i_reg_addr        (i_reg_addr),
        .i_byte_count      (i_byte_count),
        .i_buffer_index    (i_buffer_index),
        .i_data_byte       (i_data_byte),
        .i_write_done_flag (i_write_done_flag),
        .i_read_done_flag  (i_read_done_flag),
        .i_rx_nack         (i_rx_nack),
        .i_clock_hold      (i_clock_hold),
        .o_res             (res),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr)
    );

    i2crs_ram #(
        .WIDTH(8),
        .DEPTH(MAX_WRITE_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // RAM data only changes on a new accept, so it stays aligned with a stalled stage 1
    always_comb begin
        n_out = r_s1;
        if (r_s1.use_buf) begin
            n_out.command_byte = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command      = r_out.command;
    assign o_command_byte = r_out.command_byte;
    assign o_status       = r_out.status;
    assign o_read_valid   = r_out.read_valid;
    assign o_read_byte    = r_out.read_byte;
    assign o_read_index   = r_out.read_index;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the I2C register access sequencer core.
`timescale 1ns / 1ps

module testbench;

    localparam int MAXW = i2crs_pkg::MAX_WRITE_BYTES_DEF;
    localparam int BW = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        bit         is_cfg;
        logic [6:0] cfg_val;
        logic [1:0] action;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [4:0] buffer_index;
        logic [7:0] data_byte;
        logic       write_done;
        logic       read_done;
        logic       nack;
        logic       hold;
    } t_stim;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] command_byte;
        logic [2:0] status;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [7:0] read_index;
    } t_bus_cmd;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [6:0] i_cfg_wdata = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_action = '0;
    logic [7:0] i_reg_addr = '0;
    logic [7:0] i_byte_count = '0;
    logic [4:0] i_buffer_index = '0;
    logic [7:0] i_data_byte = '0;
    logic       i_write_done_flag = 1'b0;
    logic       i_read_done_flag = 1'b0;
    logic       i_rx_nack = 1'b0;
    logic       i_clock_hold = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_command;
    logic [7:0] o_command_byte;
    logic [2:0] o_status;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic [7:0] o_read_index;

    i2c_register_access_sequencer_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_action(i_action),
        .i_reg_addr(i_reg_addr),
        .i_byte_count(i_byte_count),
        .i_buffer_index(i_buffer_index),
        .i_data_byte(i_data_byte),
        .i_write_done_flag(i_write_done_flag),
        .i_read_done_flag(i_read_done_flag),
        .i_rx_nack(i_rx_nack),
        .i_clock_hold(i_clock_hold),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_command(o_command),
        .o_command_byte(o_command_byte),
        .o_status(o_status),
        .o_read_valid(o_read_valid),
        .o_read_byte(o_read_byte),
        .o_read_index(o_read_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stim    bus_items[$];
    t_bus_cmd awaited_cmds[$];
    int       stim_count = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;

    // sequencer mirror
    logic [6:0]        tgt_addr = '0;
    i2crs_pkg::t_phase seq_phase = i2crs_pkg::PH_IDLE;
    logic              seq_is_write = 1'b0;
    logic [7:0]        seq_reg = '0;
    logic [7:0]        seq_total = '0;
    logic [7:0]        seq_sent = '0;
    logic [2:0]        seq_status = i2crs_pkg::ST_BUSY;
    logic [7:0]        wbuf [MAXW];

    task automatic predict_command(input t_stim it);
        t_bus_cmd   r;
        logic [7:0] addr_w;
        bit         count_ok;
        r = '0;
        addr_w = {tgt_addr, 1'b0};
        if (it.action == i2crs_pkg::ACT_START_RD || it.action == i2crs_pkg::ACT_START_WR) begin
            count_ok = (it.action == i2crs_pkg::ACT_START_WR) ?
                       (it.byte_count >= 1 && it.byte_count <= MAXW) : (it.byte_count != 0);
            if (count_ok) begin
                seq_is_write = (it.action == i2crs_pkg::ACT_START_WR);
                seq_reg = it.reg_addr;
                seq_total = it.byte_count;
                seq_sent = '0;
                seq_status = i2crs_pkg::ST_BUSY;
                seq_phase = i2crs_pkg::PH_ADDR;
                r.command = i2crs_pkg::CMD_ADDR;
                r.command_byte = addr_w;
            end else begin
                seq_phase = i2crs_pkg::PH_IDLE;
                seq_status = i2crs_pkg::ST_REJECT;
            end
        end else if (it.action == i2crs_pkg::ACT_LOAD) begin
            if (it.buffer_index < MAXW) wbuf[it.buffer_index] = it.data_byte;
        end else begin
            case (seq_phase)
                i2crs_pkg::PH_ADDR: if (it.write_done) begin
                    if (it.hold && !it.nack) begin
                        r.command = i2crs_pkg::CMD_DATA;
                        r.command_byte = seq_reg;
                        seq_phase = i2crs_pkg::PH_REG;
                    end else if (it.nack) begin
                        r.command = i2crs_pkg::CMD_STOP;
                        seq_status = i2crs_pkg::ST_ADDRNACK;
                        seq_phase = i2crs_pkg::PH_IDLE;
                    end else begin
                        // ACK without clock hold: someone else owns the bus
                        seq_status = i2crs_pkg::ST_ARBLOST;
                        seq_phase = i2crs_pkg::PH_IDLE;
                    end
                end
                i2crs_pkg::PH_REG: if (it.write_done) begin
                    if (it.nack) begin
                        r.command = i2crs_pkg::CMD_STOP;
                        seq_status = i2crs_pkg::ST_REGNACK;
                        seq_phase = i2crs_pkg::PH_IDLE;
                    end else if (!seq_is_write) begin
                        r.command = i2crs_pkg::CMD_ADDR;
                        r.command_byte = addr_w | 8'h01;
                        seq_phase = i2crs_pkg::PH_READ;
                    end else if (seq_sent >= seq_total) begin
                        r.command = i2crs_pkg::CMD_STOP;
                        seq_status = i2crs_pkg::ST_DONE;
                        seq_phase = i2crs_pkg::PH_IDLE;
                    end else begin
                        r.command = i2crs_pkg::CMD_DATA;
                        r.command_byte = (seq_sent < MAXW) ? wbuf[seq_sent[BW-1:0]] : 8'h00;
                        seq_sent = seq_sent + 8'd1;
                    end
                end
                i2crs_pkg::PH_READ: if (it.read_done && it.hold) begin
                    r.read_valid = 1'b1;
                    r.read_byte = it.data_byte;
                    r.read_index = seq_sent;
                    seq_sent = seq_sent + 8'd1;
                    if (seq_sent == seq_total) begin
                        r.command = i2crs_pkg::CMD_NACKSTOP;
                        seq_status = i2crs_pkg::ST_DONE;
                        seq_phase = i2crs_pkg::PH_IDLE;
                    end else begin
                        r.command = i2crs_pkg::CMD_ACK;
                    end
                end
                default: ;
            endcase
        end
        r.status = seq_status;
        awaited_cmds.push_back(r);
    endtask

    // ---------------- stimulus builders ----------------
    function automatic t_stim rand_item(logic [1:0] act);
        t_stim it;
        it.is_cfg = 1'b0;
        it.cfg_val = '0;
        it.action = act;
        it.reg_addr = 8'($urandom);
        it.byte_count = 8'($urandom);
        it.buffer_index = 5'($urandom);
        it.data_byte = 8'($urandom);
        it.write_done = 1'($urandom);
        it.read_done = 1'($urandom);
        it.nack = 1'($urandom);
        it.hold = 1'($urandom);
        return it;
    endfunction

    task automatic push_item(input t_stim it);
        bus_items.push_back(it);
        stim_count++;
    endtask

    task automatic add_cfg(input logic [6:0] v);
        t_stim it;
        it = rand_item(i2crs_pkg::ACT_EVENT);
        it.is_cfg = 1'b1;
        it.cfg_val = v;
        bus_items.push_back(it);
    endtask

    task automatic add_start(input bit wr, input logic [7:0] ra, input logic [7:0] cnt);
        t_stim it;
        it = rand_item(wr ? i2crs_pkg::ACT_START_WR : i2crs_pkg::ACT_START_RD);
        it.reg_addr = ra;
        it.byte_count = cnt;
        push_item(it);
    endtask

    task automatic add_load(input logic [4:0] slot, input logic [7:0] b);
        t_stim it;
        it = rand_item(i2crs_pkg::ACT_LOAD);
        it.buffer_index = slot;
        it.data_byte = b;
        push_item(it);
    endtask

    task automatic add_event(input logic wd, input logic rd, input logic nk, input logic hd,
                             input logic [7:0] db);
        t_stim it;
        it = rand_item(i2crs_pkg::ACT_EVENT);
        it.write_done = wd;
        it.read_done = rd;
        it.nack = nk;
        it.hold = hd;
        it.data_byte = db;
        push_item(it);
    endtask

    // occasional loads and events the current phase must ignore
    task automatic add_filler(input bit reading);
        logic hd;
        if ($urandom_range(0, 7) == 0) add_load(5'($urandom), 8'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            if (reading) begin
                hd = 1'($urandom);
                add_event(1'($urandom), hd ? 1'b0 : 1'($urandom), 1'($urandom), hd,
                          8'($urandom));
            end else begin
                add_event(1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) push_item(rand_item(2'($urandom_range(0, 3))));
    endtask

    // one register transaction, possibly broken by a NACK, lost arbitration or abandonment
    task automatic add_txn();
        bit wr;
        int n;
        int fault;
        int k;
        int j;
        wr = 1'($urandom_range(0, 1));
        if (wr) n = ($urandom_range(0, 7) == 0) ? MAXW : $urandom_range(1, 8);
        else if ($urandom_range(0, 49) == 0) n = $urandom_range(1, 255);
        else n = $urandom_range(1, 10);
        fault = $urandom_range(0, 11);
        add_start(wr, 8'($urandom), 8'(n));
        add_filler(1'b0);
        if (fault == 0) begin
            add_event(1'b1, 1'($urandom), 1'b1, 1'($urandom), 8'($urandom));
            return;
        end
        if (fault == 1) begin
            add_event(1'b1, 1'($urandom), 1'b0, 1'b0, 8'($urandom));
            return;
        end
        add_event(1'b1, 1'($urandom), 1'b0, 1'b1, 8'($urandom));
        if (wr) begin
            k = $urandom_range(0, n);
            for (j = 0; j <= n; j++) begin
                if (fault == 3 && j == k) return;
                add_filler(1'b0);
                add_event(1'b1, 1'($urandom), (fault == 2 && j == k), 1'b1, 8'($urandom));
                if (fault == 2 && j == k) return;
            end
        end else begin
            add_filler(1'b0);
            add_event(1'b1, 1'($urandom), (fault == 2), 1'b1, 8'($urandom));
            if (fault == 2) return;
            k = $urandom_range(0, n - 1);
            for (j = 0; j < n; j++) begin
                if (fault == 3 && j == k) return;
                add_filler(1'b1);
                add_event(1'($urandom), 1'b1, 1'($urandom), 1'b1, 8'($urandom));
            end
        end
    endtask

    // ---------------- driver ----------------
    t_stim      drive_item;
    logic [6:0] cfg_data = '0;
    int         drv_gap = 0;
    bit         drv_quiet = 1'b0;
    int         cfg_settle = 0;

    always @(posedge i_clk) begin
        logic  nv;
        logic  we;
        t_stim head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            nv = i_valid;
            we = 1'b0;
            if (i_valid && o_ready) begin
                predict_command(drive_item);
                nv = 1'b0;
                if ($urandom_range(0, 31) == 0) drv_quiet = !drv_quiet;
                drv_gap = drv_quiet ? 0 : $urandom_range(0, 14);
            end
            if (!nv) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (bus_items.size() > 0) begin
                    head = bus_items[0];
                    if (!head.is_cfg) begin
                        drive_item = bus_items.pop_front();
                        nv = 1'b1;
                    end else if (awaited_cmds.size() == 0) begin
                        // let the result pipeline drain before touching the address
                        if (cfg_settle < 3) begin
                            cfg_settle++;
                        end else begin
                            void'(bus_items.pop_front());
                            we = 1'b1;
                            cfg_data = head.cfg_val;
                            tgt_addr = head.cfg_val;
                            cfg_settle = 0;
                            drv_gap = 2;
                        end
                    end else begin
                        cfg_settle = 0;
                    end
                end
            end
            i_valid <= nv;
            i_cfg_we <= we;
            i_cfg_wdata <= cfg_data;
            i_action <= drive_item.action;
            i_reg_addr <= drive_item.reg_addr;
            i_byte_count <= drive_item.byte_count;
            i_buffer_index <= drive_item.buffer_index;
            i_data_byte <= drive_item.data_byte;
            i_write_done_flag <= drive_item.write_done;
            i_read_done_flag <= drive_item.read_done;
            i_rx_nack <= drive_item.nack;
            i_clock_hold <= drive_item.hold;
        end
    end

    // ---------------- monitor ----------------
    int rcv_gap = 0;
    bit rcv_quiet = 1'b0;

    always @(posedge i_clk) begin
        logic     nr;
        t_bus_cmd want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            nr = i_ready;
            if (o_valid && i_ready) begin
                if (awaited_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: cmd %0d byte %h status %0d",
                                 o_command, o_command_byte, o_status);
                end else begin
                    want = awaited_cmds.pop_front();
                    if (o_command !== want.command || o_command_byte !== want.command_byte ||
                        o_status !== want.status || o_read_valid !== want.read_valid ||
                        o_read_byte !== want.read_byte || o_read_index !== want.read_index) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch (exp/got): cmd %0d/%0d byte %h/%h status %0d/%0d",
                                   want.command, o_command, want.command_byte, o_command_byte,
                                   want.status, o_status);
                            $display(" rvalid %b/%b rbyte %h/%h ridx %0d/%0d",
                                     want.read_valid, o_read_valid, want.read_byte,
                                     o_read_byte, want.read_index, o_read_index);
                        end
                    end
                end
                if ($urandom_range(0, 31) == 0) rcv_quiet = !rcv_quiet;
                rcv_gap = rcv_quiet ? 0 : $urandom_range(0, 14);
                nr = (rcv_gap == 0);
            end else if (!nr) begin
                if (rcv_gap > 0) rcv_gap--;
                if (rcv_gap == 0) nr = 1'b1;
            end
            i_ready <= nr;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------- sequence ----------------
    initial begin
        int p;
        int s;
        int phase_end;

        add_cfg(7'h00);
        // every buffer slot is loaded before anything can send from it
        for (s = 0; s < MAXW; s++)
            add_load(5'(s), (s == 0) ? 8'h00 : (s == MAXW - 1) ? 8'hFF : 8'($urandom));

        add_event(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);       // idle event, status still busy
        add_start(1'b0, 8'h12, 8'd0);                   // read count zero rejected
        add_start(1'b1, 8'h34, 8'd0);                   // write counts out of range
        add_start(1'b1, 8'h34, 8'(MAXW + 1));
        add_start(1'b1, 8'hFF, 8'd255);
        add_start(1'b1, 8'hFF, 8'd1);                   // complete one-byte write
        add_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        add_event(1'b0, 1'b1, 1'b0, 1'b1, 8'h00);       // no write done: ignored
        add_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        add_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        add_start(1'b1, 8'h00, 8'(MAXW));               // lost arbitration
        add_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        add_start(1'b0, 8'h55, 8'd1);                   // address NACK
        add_event(1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
        add_event(1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
        add_start(1'b1, 8'hAA, 8'd2);                   // register NACK
        add_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        add_event(1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
        add_cfg(7'h7F);
        add_start(1'b0, 8'h00, 8'd2);                   // two-byte read
        add_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        add_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        add_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h5A);       // read done without hold: ignored
        add_event(1'b1, 1'b1, 1'b0, 1'b1, 8'hFF);
        add_event(1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
        add_start(1'b0, 8'h01, 8'd255);                 // restart while busy
        add_start(1'b1, 8'h02, 8'd1);
        repeat (3) add_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);

        for (p = 0; p < 7; p++) begin
            add_cfg((p == 0) ? 7'h7F : (p == 1) ? 7'h00 : 7'($urandom_range(0, 127)));
            phase_end = stim_count + 250;
            while (stim_count < phase_end) begin
                if ($urandom_range(0, 5) == 0) add_noise();
                else add_txn();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((bus_items.size() > 0 || i_valid || awaited_cmds.size() > 0) &&
               quiet_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);

        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: done, errors");
        end else begin
            repeat (10) @(negedge i_clk);
            if (awaited_cmds.size() != 0) begin
                $display("%0d expected transactions never arrived", awaited_cmds.size());
                mismatches++;
            end
            if (mismatches == 0) $display("testbench: done, clean");
            else $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
design/i2crs_pkg.sv
design/i2crs_ram.sv
design/i2crs_ctrl.sv
design/i2c_register_access_sequencer_core.sv
verif/testbench.sv
